@@ sv/lqc_pkg.sv @@
// lqc_pkg: shared types and codes for the linked queue with cancel
// beat structs for the command and response channels, operation and entry status codes
// no dependencies

package lqc_pkg;

	localparam int KIND_W  = 2;
	localparam int ENTRY_W = 6;
	localparam int OCC_W   = 7;
	localparam int STAT_W  = 2;

	localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd2;

	localparam logic [STAT_W-1:0] ENT_NEVER     = 2'd0;
	localparam logic [STAT_W-1:0] ENT_QUEUED    = 2'd1;
	localparam logic [STAT_W-1:0] ENT_READ      = 2'd2;
	localparam logic [STAT_W-1:0] ENT_CANCELLED = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ENTRY_W-1:0] entry;
	} cmd_t;

	typedef struct packed {
		logic               ok;
		logic [ENTRY_W-1:0] popped_entry;
		logic               error;
		logic [OCC_W-1:0]   occupancy;
	} rsp_t;

endpackage

@@ sv/lqc_ram.sv @@
// lqc_ram: generic single write port, single read port memory
// registered read data with read enable, no reset on contents
// no dependencies

module lqc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/linked_queue_with_cancel.sv @@
// linked_queue_with_cancel: fifo over a pool of entry slots kept as a doubly linked list
// depends on lqc_pkg for beat types and codes, and on lqc_ram for link and status memories
//
//   channel  dir  handshake             payload
//   cmd      in   cmd_valid/cmd_stall   lqc_pkg::cmd_t (kind, entry)
//   rsp      out  rsp_valid/rsp_stall   lqc_pkg::rsp_t (ok, popped_entry, error, occupancy)
//
// one command at a time; a push onto a non-empty queue adds a link state, since both
// link writes of a push go through the single write port of the next-link memory
// after reset the status memory is swept to never-queued, with cmd_stall high
// the response sits in an output register; a stalled response holds the next command
// in its evaluate cycle until the register frees up

module linked_queue_with_cancel #(
	parameter int ENTRIES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  lqc_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lqc_pkg::rsp_t rsp
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int LW = IW + 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [LW-1:0] LINK_NIL = {1'b1, {IW{1'b0}}};

	typedef enum logic [3:0] {
		SQ_CLEAR = 4'b0001,
		SQ_IDLE  = 4'b0010,
		SQ_EVAL  = 4'b0100,
		SQ_LINK  = 4'b1000
	} seq_state_t;

	seq_state_t state_q;
	logic [IW-1:0] clr_q;
	logic [LW-1:0] head_q;
	logic [LW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [lqc_pkg::KIND_W-1:0]  op_kind_q;
	logic [lqc_pkg::ENTRY_W-1:0] op_entry_q;
	logic rsp_valid_q;
	lqc_pkg::rsp_t rsp_q;

	logic accept;
	logic [IW-1:0] cmd_idx;

	logic st_we, nx_we, pv_we;
	logic [IW-1:0] st_waddr, nx_waddr, pv_waddr;
	logic [lqc_pkg::STAT_W-1:0] st_wdata, st_rd;
	logic [LW-1:0] nx_wdata, pv_wdata, nx_rd, pv_rd;
	logic [IW-1:0] nx_raddr;

	logic [IW-1:0] e_idx;
	logic [LW-1:0] e_link;
	logic slot_ok, head_ok, tail_ok, nx_ok, pv_ok;
	logic is_push, push_err, push_go, pop_go, is_cancel, can_go, can_ok;
	logic out_free, fire;
	logic [LW-1:0] head_nx, tail_nx;
	logic [CW-1:0] count_nx;
	lqc_pkg::rsp_t rsp_nx;

	assign cmd_stall = (state_q != SQ_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_idx   = IW'(cmd.entry);
	assign nx_raddr  = (cmd.kind == lqc_pkg::KIND_POP) ? head_q[IW-1:0] : cmd_idx;

	lqc_ram #(.WIDTH(lqc_pkg::STAT_W), .DEPTH(ENTRIES)) u_status (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.re(accept), .raddr(cmd_idx), .rdata(st_rd)
	);

	lqc_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
		.re(accept), .raddr(nx_raddr), .rdata(nx_rd)
	);

	lqc_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
		.re(accept), .raddr(cmd_idx), .rdata(pv_rd)
	);

	// decode of the held command against the read data
	assign e_idx   = IW'(op_entry_q);
	assign e_link  = {1'b0, e_idx};
	assign slot_ok = (32'(op_entry_q) < ENTRIES);
	assign head_ok = !head_q[IW];
	assign tail_ok = !tail_q[IW];
	assign nx_ok   = !nx_rd[IW];
	assign pv_ok   = !pv_rd[IW];

	assign is_push   = (op_kind_q == lqc_pkg::KIND_PUSH) && slot_ok;
	assign push_err  = is_push && (st_rd == lqc_pkg::ENT_QUEUED);
	assign push_go   = is_push && !push_err;
	assign pop_go    = (op_kind_q == lqc_pkg::KIND_POP) && (count_q != '0) && head_ok;
	assign is_cancel = (op_kind_q == lqc_pkg::KIND_CANCEL) && slot_ok;
	assign can_go    = is_cancel && (st_rd == lqc_pkg::ENT_QUEUED);
	assign can_ok    = can_go || (is_cancel && (st_rd == lqc_pkg::ENT_CANCELLED));

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign fire     = (state_q == SQ_EVAL) && out_free;

	always_comb begin
		st_we    = 1'b0;
		st_waddr = e_idx;
		st_wdata = lqc_pkg::ENT_NEVER;
		nx_we    = 1'b0;
		nx_waddr = e_idx;
		nx_wdata = LINK_NIL;
		pv_we    = 1'b0;
		pv_waddr = e_idx;
		pv_wdata = LINK_NIL;
		head_nx  = head_q;
		tail_nx  = tail_q;
		count_nx = count_q;
		if (state_q == SQ_CLEAR) begin
			st_we    = 1'b1;
			st_waddr = clr_q;
		end else if (state_q == SQ_LINK) begin
			nx_we = 1'b1;
		end else if (fire && push_go) begin
			st_we    = 1'b1;
			st_wdata = lqc_pkg::ENT_QUEUED;
			nx_we    = 1'b1;
			if (tail_ok) begin
				nx_waddr = tail_q[IW-1:0];
				nx_wdata = e_link;
			end else begin
				head_nx = e_link;
			end
			pv_we    = 1'b1;
			pv_wdata = tail_q;
			tail_nx  = e_link;
			count_nx = count_q + CW'(1);
		end else if (fire && pop_go) begin
			st_we    = 1'b1;
			st_waddr = head_q[IW-1:0];
			st_wdata = lqc_pkg::ENT_READ;
			if (head_q == tail_q) begin
				head_nx = LINK_NIL;
				tail_nx = LINK_NIL;
			end else begin
				head_nx  = nx_rd;
				pv_we    = nx_ok;
				pv_waddr = nx_rd[IW-1:0];
			end
			count_nx = count_q - CW'(1);
		end else if (fire && can_go) begin
			st_we    = 1'b1;
			st_wdata = lqc_pkg::ENT_CANCELLED;
			if (head_q == e_link) begin
				head_nx = nx_rd;
			end
			if (tail_q == e_link) begin
				tail_nx = pv_rd;
			end
			nx_we    = pv_ok;
			nx_waddr = pv_rd[IW-1:0];
			nx_wdata = nx_rd;
			pv_we    = nx_ok;
			pv_waddr = nx_rd[IW-1:0];
			pv_wdata = pv_rd;
			if (count_q != '0) begin
				count_nx = count_q - CW'(1);
			end
		end
	end

	always_comb begin
		rsp_nx.ok           = push_go || pop_go || can_ok;
		rsp_nx.popped_entry = pop_go ? lqc_pkg::ENTRY_W'(head_q[IW-1:0]) : '0;
		rsp_nx.error        = push_err;
		rsp_nx.occupancy    = lqc_pkg::OCC_W'(count_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_CLEAR;
			clr_q       <= '0;
			head_q      <= LINK_NIL;
			tail_q      <= LINK_NIL;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			head_q  <= head_nx;
			tail_q  <= tail_nx;
			count_q <= count_nx;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				SQ_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(ENTRIES - 1)) begin
						state_q <= SQ_IDLE;
					end
				end
				SQ_IDLE: begin
					if (accept) begin
						state_q <= SQ_EVAL;
					end
				end
				SQ_EVAL: begin
					if (fire) begin
						state_q <= (push_go && tail_ok) ? SQ_LINK : SQ_IDLE;
					end
				end
				SQ_LINK: begin
					state_q <= SQ_IDLE;
				end
				default: begin
					state_q <= SQ_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_kind_q  <= cmd.kind;
			op_entry_q <= cmd.entry;
		end
		if (fire) begin
			rsp_q <= rsp_nx;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ sv/lqc_checker.sv @@
// lqc_port_checks: port-level checks for linked_queue_with_cancel, bound to the top level
// depends on lqc_pkg for beat types

module lqc_port_checks #(
	parameter int ENTRIES = 64
) (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input lqc_pkg::cmd_t cmd,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input lqc_pkg::rsp_t rsp
);

	// stalled response beat holds
	ap_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// one command at a time
	ap_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken in back-to-back cycles");

	ap_err_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.error && rsp.ok))
		else $error("response flags both error and ok");

	ap_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.popped_entry != '0) |-> rsp.ok)
		else $error("popped entry reported on a failed operation");

	ap_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (ENTRIES > 127) || (32'(rsp.occupancy) <= ENTRIES))
		else $error("occupancy beyond pool size");

endmodule

bind linked_queue_with_cancel lqc_port_checks #(.ENTRIES(ENTRIES)) u_lqc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.cmd(cmd),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp(rsp)
);
